>>> sv/bcis_pkg.sv
// Package for the basic computer instruction step core: beat structs, operation,
// opcode and ALU codes, and the address wrap helpers.
// No dependencies.
`timescale 1ns / 1ps

package bcis_pkg;

   localparam int MEM_WORDS = 4096;
   localparam int ADDR_W = $clog2(MEM_WORDS);

   // The address wrap is a reciprocal multiply with a single correction step.
   localparam int RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP = 21'((2 ** RECIP_SHIFT) / MEM_WORDS);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_STEP  = 2'd3;

   localparam logic [2:0] OPC_AND = 3'd0;
   localparam logic [2:0] OPC_ADD = 3'd1;
   localparam logic [2:0] OPC_LDA = 3'd2;
   localparam logic [2:0] OPC_STA = 3'd3;
   localparam logic [2:0] OPC_BUN = 3'd4;
   localparam logic [2:0] OPC_BSA = 3'd5;
   localparam logic [2:0] OPC_ISZ = 3'd6;
   localparam logic [2:0] OPC_REG = 3'd7;

   localparam int RR_CLA = 11;
   localparam int RR_CLE = 10;
   localparam int RR_CMA = 9;
   localparam int RR_CME = 8;
   localparam int RR_CIR = 7;
   localparam int RR_CIL = 6;
   localparam int RR_INC = 5;
   localparam int RR_SPA = 4;
   localparam int RR_SNA = 3;
   localparam int RR_SZA = 2;
   localparam int RR_SZE = 1;
   localparam int RR_HLT = 0;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_AND = 3'd1;
   localparam logic [2:0] ALU_NOT = 3'd2;
   localparam logic [2:0] ALU_ROR = 3'd3;
   localparam logic [2:0] ALU_ROL = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] addr;
      logic [15:0] data;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] instr;
      logic [11:0] pc_out;
      logic [15:0] acc_out;
      logic        e_out;
      logic        running;
   } rsp_type;

   typedef struct packed {
      logic [2:0] func;
      logic       e;
   } alu_ctrl_type;

   typedef struct packed {
      logic [15:0] value;
      logic        carry;
   } alu_res_type;

   // Quotient estimate of a / MEM_WORDS; it is low by at most one.
   function automatic logic [11:0] wrap_quot(input logic [11:0] a);
      logic [35:0] prod;
      prod = 36'(a) * 36'(RECIP);
      return prod[RECIP_SHIFT +: 12];
   endfunction

   // Remainder from the registered quotient estimate, with one correction.
   function automatic logic [ADDR_W-1:0] wrap_fix(input logic [11:0] a,
                                                  input logic [11:0] quot);
      logic [24:0] back;
      logic [12:0] rem;
      back = 25'(quot) * 25'(MEM_WORDS);
      rem = 13'(a) - back[12:0];
      if (rem >= 13'(MEM_WORDS)) begin
         rem = rem - 13'(MEM_WORDS);
      end
      return rem[ADDR_W-1:0];
   endfunction

endpackage

>>> sv/bcis_alu.sv
// Shared arithmetic and logic unit of the instruction step core.
// Depends on bcis_pkg for the control and result structs and the function codes.
`timescale 1ns / 1ps

module bcis_alu import bcis_pkg::*; (
   input  alu_ctrl_type ctrl,
   input  logic [15:0]  opnd_a,
   input  logic [15:0]  opnd_b,
   output alu_res_type  res
);

   logic [16:0] sum;

   assign sum = {1'b0, opnd_a} + {1'b0, opnd_b};

   always_comb begin
      unique case (ctrl.func)
         ALU_ADD: res = '{value: sum[15:0], carry: sum[16]};
         ALU_AND: res = '{value: opnd_a & opnd_b, carry: 1'b0};
         ALU_NOT: res = '{value: ~opnd_a, carry: 1'b0};
         ALU_ROR: res = '{value: {ctrl.e, opnd_a[15:1]}, carry: opnd_a[0]};
         ALU_ROL: res = '{value: {opnd_a[14:0], ctrl.e}, carry: opnd_a[15]};
         default: res = '{value: sum[15:0], carry: sum[16]};
      endcase
   end

endmodule

>>> sv/basic_computer_instruction_step_core.sv
// Basic computer instruction step core: sequencer, registers and word memory.
// Depends on bcis_pkg and bcis_alu.
// Beats go one at a time: start, and step while stopped, go straight to the result;
// load and read access memory; a running step does fetch, optional indirect read,
// operand access and ISZ skip test. A new beat is accepted only after the previous
// result is registered. After reset a clearing pass zeroes the memory, req_ready low.
`timescale 1ns / 1ps

module basic_computer_instruction_step_core import bcis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_item,
   input  logic        csr_write_en,
   input  logic [11:0] csr_write_data
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_WRITE  = 4'd2;
   localparam logic [3:0] ST_READ   = 4'd3;
   localparam logic [3:0] ST_READ2  = 4'd4;
   localparam logic [3:0] ST_FETCH  = 4'd5;
   localparam logic [3:0] ST_DECODE = 4'd6;
   localparam logic [3:0] ST_IND    = 4'd7;
   localparam logic [3:0] ST_INDEA  = 4'd8;
   localparam logic [3:0] ST_OPER   = 4'd9;
   localparam logic [3:0] ST_OPEX   = 4'd10;
   localparam logic [3:0] ST_ISZ    = 4'd11;
   localparam logic [3:0] ST_REGREF = 4'd12;
   localparam logic [3:0] ST_DONE   = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [11:0]       pc_ff, pc_in;
   logic [15:0]       acc_ff, acc_in;
   logic              e_ff, e_in;
   logic              run_ff, run_in;
   logic [11:0]       start_pc_ff, start_pc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [15:0]       ir_ff, ir_in;
   logic [11:0]       ea_ff, ea_in;
   logic [15:0]       data_ff, data_in;
   logic [15:0]       rd_ff, rd_in;
   logic [11:0]       mar_ff, mar_quot_ff;
   logic [15:0]       mem_rd_ff;

   logic              mar_load;
   logic [11:0]       mar_src;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [15:0]       mem_wdata;
   alu_ctrl_type      alu_ctrl;
   logic [15:0]       alu_a, alu_b;
   alu_res_type       alu_res;
   logic [2:0]        opc;

   logic [15:0] mem [MEM_WORDS];

   bcis_alu u_alu (
      .ctrl   (alu_ctrl),
      .opnd_a (alu_a),
      .opnd_b (alu_b),
      .res    (alu_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
   assign opc = ir_ff[14:12];
   assign start_pc_in = csr_write_en ? csr_write_data : start_pc_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      pc_in = pc_ff;
      acc_in = acc_ff;
      e_in = e_ff;
      run_in = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      ir_in = ir_ff;
      ea_in = ea_ff;
      data_in = data_ff;
      rd_in = rd_ff;
      mar_load = 1'b0;
      mar_src = ea_ff;
      mem_we = 1'b0;
      mem_wdata = acc_ff;
      alu_ctrl = '{func: ALU_ADD, e: e_ff};
      alu_a = acc_ff;
      alu_b = 16'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wdata = 16'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rd_in = 16'd0;
               ir_in = 16'd0;
               data_in = req_item.data;
               mar_src = req_item.addr;
               unique case (req_item.op)
                  OP_LOAD: begin
                     mar_load = 1'b1;
                     state_in = ST_WRITE;
                  end
                  OP_READ: begin
                     mar_load = 1'b1;
                     state_in = ST_READ;
                  end
                  OP_START: begin
                     pc_in = start_pc_ff;
                     run_in = 1'b1;
                     state_in = ST_DONE;
                  end
                  default: begin
                     if (run_ff) begin
                        mar_src = pc_ff;
                        mar_load = 1'b1;
                        state_in = ST_FETCH;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            mem_wdata = data_ff;
            state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_READ2;
         end
         ST_READ2: begin
            rd_in = mem_rd_ff;
            state_in = ST_DONE;
         end
         ST_FETCH: begin
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            ir_in = mem_rd_ff;
            ea_in = mem_rd_ff[11:0];
            alu_a = {4'd0, pc_ff};
            alu_b = 16'd1;
            pc_in = alu_res.value[11:0];
            mar_src = mem_rd_ff[11:0];
            if (mem_rd_ff[14:12] == OPC_REG) begin
               state_in = mem_rd_ff[15] ? ST_DONE : ST_REGREF;
            end else begin
               mar_load = 1'b1;
               state_in = mem_rd_ff[15] ? ST_IND : ST_OPER;
            end
         end
         ST_IND: begin
            state_in = ST_INDEA;
         end
         ST_INDEA: begin
            ea_in = mem_rd_ff[11:0];
            mar_src = mem_rd_ff[11:0];
            mar_load = 1'b1;
            state_in = ST_OPER;
         end
         ST_OPER: begin
            state_in = ST_OPEX;
            case (opc)
               OPC_STA: begin
                  mem_we = 1'b1;
                  mem_wdata = acc_ff;
                  state_in = ST_DONE;
               end
               OPC_BUN: begin
                  pc_in = ea_ff;
                  state_in = ST_DONE;
               end
               OPC_BSA: begin
                  mem_we = 1'b1;
                  mem_wdata = {4'd0, pc_ff};
                  alu_a = {4'd0, ea_ff};
                  alu_b = 16'd1;
                  pc_in = alu_res.value[11:0];
                  state_in = ST_DONE;
               end
               default: begin
               end
            endcase
         end
         ST_OPEX: begin
            state_in = ST_DONE;
            alu_b = mem_rd_ff;
            case (opc)
               OPC_AND: begin
                  alu_ctrl.func = ALU_AND;
                  acc_in = alu_res.value;
               end
               OPC_ADD: begin
                  acc_in = alu_res.value;
                  e_in = alu_res.carry;
               end
               OPC_LDA: begin
                  acc_in = mem_rd_ff;
               end
               default: begin
                  alu_a = 16'd1;
                  mem_we = 1'b1;
                  mem_wdata = alu_res.value;
                  data_in = alu_res.value;
                  state_in = ST_ISZ;
               end
            endcase
         end
         ST_ISZ: begin
            alu_a = {4'd0, pc_ff};
            alu_b = 16'd1;
            if (data_ff == 16'd0) begin
               pc_in = alu_res.value[11:0];
            end
            state_in = ST_DONE;
         end
         ST_REGREF: begin
            state_in = ST_DONE;
            alu_b = 16'd1;
            if (ir_ff[RR_CLA]) begin
               acc_in = 16'd0;
            end else if (ir_ff[RR_CLE]) begin
               e_in = 1'b0;
            end else if (ir_ff[RR_CMA]) begin
               alu_ctrl.func = ALU_NOT;
               acc_in = alu_res.value;
            end else if (ir_ff[RR_CME]) begin
               e_in = !e_ff;
            end else if (ir_ff[RR_CIR]) begin
               alu_ctrl.func = ALU_ROR;
               acc_in = alu_res.value;
               e_in = alu_res.carry;
            end else if (ir_ff[RR_CIL]) begin
               alu_ctrl.func = ALU_ROL;
               acc_in = alu_res.value;
               e_in = alu_res.carry;
            end else if (ir_ff[RR_INC]) begin
               acc_in = alu_res.value;
               e_in = e_ff | alu_res.carry;
            end else begin
               alu_a = {4'd0, pc_ff};
               if ((ir_ff[RR_SPA] && !acc_ff[15])
                   || (!ir_ff[RR_SPA] && ir_ff[RR_SNA] && acc_ff[15])
                   || (!ir_ff[RR_SPA] && !ir_ff[RR_SNA] && ir_ff[RR_SZA]
                       && (acc_ff == 16'd0))
                   || (!ir_ff[RR_SPA] && !ir_ff[RR_SNA] && !ir_ff[RR_SZA]
                       && ir_ff[RR_SZE] && !e_ff)) begin
                  pc_in = alu_res.value[11:0];
               end
               if (ir_ff[RR_SPA:RR_SZE] == 4'd0 && ir_ff[RR_HLT]) begin
                  run_in = 1'b0;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{read_data: rd_ff, instr: ir_ff, pc_out: pc_ff,
                          acc_out: acc_ff, e_out: e_ff, running: run_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mem_addr = (state_ff == ST_CLEAR) ? clr_ff : wrap_fix(mar_ff, mar_quot_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         pc_ff <= 12'd0;
         acc_ff <= 16'd0;
         e_ff <= 1'b0;
         run_ff <= 1'b0;
         start_pc_ff <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pc_ff <= pc_in;
         acc_ff <= acc_in;
         e_ff <= e_in;
         run_ff <= run_in;
         start_pc_ff <= start_pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      ir_ff <= ir_in;
      ea_ff <= ea_in;
      data_ff <= data_in;
      rd_ff <= rd_in;
      if (mar_load) begin
         mar_ff <= mar_src;
         mar_quot_ff <= wrap_quot(mar_src);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_addr];
   end

endmodule

>>> test/tb_basic_computer_instruction_step_core.sv
// Self-checking testbench for basic_computer_instruction_step_core: directed programs
// and random programs through the request, result and start_pc register ports.
// Depends on bcis_pkg and the core itself.
`timescale 1ns / 1ps

module tb_basic_computer_instruction_step_core import bcis_pkg::*;;

   localparam int HOLD_CYCLES = 100;
   localparam int WINDOW = 32;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_item;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_item;
   logic        csr_write_en;
   logic [11:0] csr_write_data;

   // Machine state as the core should hold it.
   logic [15:0] mem_image [0:MEM_WORDS-1];
   logic [11:0] pc_q;
   logic [15:0] ac_q;
   logic        e_q;
   logic        run_q;
   logic [11:0] start_pc_q;

   rsp_type     state_snapshot_q [$];

   int beats_sent;
   int op_count [4];
   int instr_count;
   int results_seen;
   int fault_count;
   int hold_asked;
   int hold_taken;
   int hold_left;
   bit steady;

   basic_computer_instruction_step_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] mem_instr(logic ind, logic [2:0] opc, logic [11:0] a);
      return {ind, opc, a};
   endfunction

   function automatic logic [15:0] reg_instr(int bitpos);
      return {1'b0, OPC_REG, 12'(1 << bitpos)};
   endfunction

   // Applies one beat to the machine state and returns the result it must produce.
   function automatic rsp_type machine_step(req_type b);
      rsp_type     r;
      logic [15:0] ir;
      logic [15:0] w;
      logic [11:0] ea;
      logic [16:0] sum;
      r = '0;
      case (b.op)
         OP_LOAD: mem_image[b.addr] = b.data;
         OP_READ: r.read_data = mem_image[b.addr];
         OP_START: begin
            pc_q = start_pc_q;
            run_q = 1'b1;
         end
         default: begin
            if (run_q) begin
               instr_count++;
               ir = mem_image[pc_q];
               r.instr = ir;
               pc_q = pc_q + 12'd1;
               ea = ir[11:0];
               if (ir[14:12] == OPC_REG) begin
                  if (!ir[15]) begin
                     if (ir[RR_CLA]) begin
                        ac_q = '0;
                     end else if (ir[RR_CLE]) begin
                        e_q = 1'b0;
                     end else if (ir[RR_CMA]) begin
                        ac_q = ~ac_q;
                     end else if (ir[RR_CME]) begin
                        e_q = ~e_q;
                     end else if (ir[RR_CIR]) begin
                        {ac_q, e_q} = {e_q, ac_q};
                     end else if (ir[RR_CIL]) begin
                        {e_q, ac_q} = {ac_q, e_q};
                     end else if (ir[RR_INC]) begin
                        sum = {1'b0, ac_q} + 17'd1;
                        ac_q = sum[15:0];
                        if (sum[16]) begin
                           e_q = 1'b1;
                        end
                     end else if (ir[RR_SPA]) begin
                        if (!ac_q[15]) begin
                           pc_q = pc_q + 12'd1;
                        end
                     end else if (ir[RR_SNA]) begin
                        if (ac_q[15]) begin
                           pc_q = pc_q + 12'd1;
                        end
                     end else if (ir[RR_SZA]) begin
                        if (ac_q == 16'd0) begin
                           pc_q = pc_q + 12'd1;
                        end
                     end else if (ir[RR_SZE]) begin
                        if (!e_q) begin
                           pc_q = pc_q + 12'd1;
                        end
                     end else if (ir[RR_HLT]) begin
                        run_q = 1'b0;
                     end
                  end
               end else begin
                  if (ir[15]) begin
                     ea = mem_image[ea][11:0];
                  end
                  case (ir[14:12])
                     OPC_AND: ac_q = ac_q & mem_image[ea];
                     OPC_ADD: begin
                        sum = {1'b0, ac_q} + {1'b0, mem_image[ea]};
                        {e_q, ac_q} = sum;
                     end
                     OPC_LDA: ac_q = mem_image[ea];
                     OPC_STA: mem_image[ea] = ac_q;
                     OPC_BUN: pc_q = ea;
                     OPC_BSA: begin
                        mem_image[ea] = {4'd0, pc_q};
                        pc_q = ea + 12'd1;
                     end
                     default: begin
                        w = mem_image[ea] + 16'd1;
                        mem_image[ea] = w;
                        if (w == 16'd0) begin
                           pc_q = pc_q + 12'd1;
                        end
                     end
                  endcase
               end
            end
         end
      endcase
      r.pc_out = pc_q;
      r.acc_out = ac_q;
      r.e_out = e_q;
      r.running = run_q;
      return r;
   endfunction

   // A word for a program window: mostly instructions aimed at the window, some pointers.
   function automatic logic [15:0] window_word(logic [11:0] base);
      int          k;
      int          bitpos;
      logic [11:0] off;
      logic        ind;
      k = $urandom_range(0, 99);
      off = base + 12'($urandom_range(0, WINDOW - 1));
      ind = ($urandom_range(0, 2) == 0);
      bitpos = $urandom_range(1, 11);
      if (k < 45) begin
         return mem_instr(ind, 3'($urandom_range(0, 6)), off);
      end else if (k < 75) begin
         return {1'b0, OPC_REG, 12'(1 << bitpos) | (12'($urandom) & 12'((1 << bitpos) - 1))};
      end else if (k < 78) begin
         return reg_instr(RR_HLT);
      end else if (k < 80) begin
         return mem_instr(1'b1, OPC_REG, 12'($urandom));
      end else if (k < 81) begin
         return mem_instr(1'b0, OPC_REG, 12'd0);
      end else if (k < 92) begin
         return {4'($urandom), off};
      end
      return 16'($urandom);
   endfunction

   task automatic send_beat(input logic [1:0] op, input logic [11:0] addr,
                            input logic [15:0] data);
      req_type b;
      b.op = op;
      b.addr = addr;
      b.data = data;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      state_snapshot_q.push_back(machine_step(b));
      beats_sent++;
      op_count[op]++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (state_snapshot_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_start_pc(input logic [11:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      start_pc_q = value;
   endtask

   task automatic run_program(input logic [11:0] base, input int n_ops);
      logic [11:0] a;
      int          k;
      set_start_pc(base);
      for (int i = 0; i < WINDOW; i++) begin
         a = base + 12'(i);
         send_beat(OP_LOAD, a, window_word(base));
      end
      send_beat(OP_START, 12'($urandom), 16'($urandom));
      for (int i = 0; i < n_ops; i++) begin
         k = $urandom_range(0, 99);
         a = base + 12'($urandom_range(0, WINDOW - 1));
         if (k < 80) begin
            send_beat(OP_STEP, 12'($urandom), 16'($urandom));
         end else if (k < 88) begin
            send_beat(OP_READ, a, 16'($urandom));
         end else if (k < 93) begin
            send_beat(OP_LOAD, a, window_word(base));
         end else if (k < 96) begin
            send_beat(OP_START, 12'($urandom), 16'($urandom));
         end else begin
            send_beat(2'($urandom), 12'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic test_after_reset();
      send_beat(OP_READ, 12'h000, 16'hFFFF);
      send_beat(OP_READ, 12'hFFF, 16'h0000);
      send_beat(OP_STEP, 12'h000, 16'h0000);
   endtask

   // Runs across the top of memory: complement and increment of all ones, an I/O
   // instruction, an empty register reference, an indirect ISZ that skips, BSA,
   // an indirect ADD with E set beforehand, then halt and a step while stopped.
   task automatic test_wrap_program();
      set_start_pc(12'hFFE);
      send_beat(OP_LOAD, 12'hFFE, reg_instr(RR_CMA));
      send_beat(OP_LOAD, 12'hFFF, reg_instr(RR_INC));
      send_beat(OP_LOAD, 12'h000, mem_instr(1'b1, OPC_REG, 12'h0A5));
      send_beat(OP_LOAD, 12'h001, mem_instr(1'b0, OPC_REG, 12'h000));
      send_beat(OP_LOAD, 12'h002, mem_instr(1'b1, OPC_ISZ, 12'h010));
      send_beat(OP_LOAD, 12'h010, 16'hC011);
      send_beat(OP_LOAD, 12'h011, 16'hFFFF);
      send_beat(OP_LOAD, 12'h004, mem_instr(1'b0, OPC_BSA, 12'h020));
      send_beat(OP_LOAD, 12'h021, mem_instr(1'b1, OPC_ADD, 12'h030));
      send_beat(OP_LOAD, 12'h030, 16'hA031);
      send_beat(OP_LOAD, 12'h031, 16'hFFFF);
      send_beat(OP_LOAD, 12'h022, reg_instr(RR_HLT));
      send_beat(OP_START, 12'h000, 16'h0000);
      repeat (9) begin
         send_beat(OP_STEP, 12'hFFF, 16'hFFFF);
      end
      send_beat(OP_READ, 12'h020, 16'h0000);
      send_beat(OP_READ, 12'h011, 16'h0000);
   endtask

   task automatic test_random_programs();
      int n;
      n = 0;
      while (beats_sent < 480) begin
         if (n == 0) begin
            run_program(12'h000, 36);
         end else if (n == 1) begin
            run_program(12'hFFF, 36);
         end else begin
            run_program(12'($urandom), $urandom_range(24, 48));
         end
         n++;
      end
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      run_program(12'($urandom), 48);
      run_program(12'($urandom), 48);
      wait_idle();
      steady = 1'b0;
   endtask

   task automatic test_receiver_stall();
      wait_idle();
      hold_asked++;
      run_program(12'($urandom), 36);
   endtask

   task automatic test_noise();
      for (int i = 0; i < 40; i++) begin
         send_beat(2'($urandom), 12'($urandom), 16'($urandom));
      end
   endtask

   always @(negedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 14) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (state_snapshot_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("%0t: result beat with nothing outstanding: %p", $realtime, rsp_item);
            end
         end else begin
            due = state_snapshot_q.pop_front();
            results_seen++;
            if (rsp_item.read_data !== due.read_data || rsp_item.instr !== due.instr ||
                rsp_item.pc_out !== due.pc_out || rsp_item.acc_out !== due.acc_out ||
                rsp_item.e_out !== due.e_out || rsp_item.running !== due.running) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("%0t: result %0d mismatch", $realtime, results_seen);
                  $display("   expected rd=%h ir=%h pc=%h ac=%h e=%b run=%b",
                           due.read_data, due.instr, due.pc_out, due.acc_out,
                           due.e_out, due.running);
                  $display("   actual   rd=%h ir=%h pc=%h ac=%h e=%b run=%b",
                           rsp_item.read_data, rsp_item.instr, rsp_item.pc_out,
                           rsp_item.acc_out, rsp_item.e_out, rsp_item.running);
               end
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("basic_computer_instruction_step_core verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      for (int i = 0; i < MEM_WORDS; i++) begin
         mem_image[i] = '0;
      end
      pc_q = '0;
      ac_q = '0;
      e_q = 1'b0;
      run_q = 1'b0;
      start_pc_q = '0;
      steady = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_wrap_program();
      test_random_programs();
      test_steady_stream();
      test_receiver_stall();
      test_noise();

      wait_idle();
      repeat (16) @(posedge clock);
      $display("Sent %0d beats: %0d loads, %0d reads, %0d starts, %0d steps.",
               beats_sent, op_count[OP_LOAD], op_count[OP_READ], op_count[OP_START],
               op_count[OP_STEP]);
      $display("Executed %0d instructions and compared %0d result beats.",
               instr_count, results_seen);
      if (fault_count == 0 && state_snapshot_q.size() == 0) begin
         $display("basic_computer_instruction_step_core verification clean");
      end else begin
         $display("basic_computer_instruction_step_core verification failed");
      end
      $finish;
   end

endmodule
